// File: hw/rtl/linked_list_queue_manager_top_assert.svh
// Assertion macros for the queue manager RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LLQM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LLQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/llqm_pkg.sv
// Shared types and constants for the linked-list queue manager.
// No dependencies.
package llqm_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int ENTRY_W  = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ENQUEUE = 2'd0;
  localparam op_t OP_DEQUEUE = 2'd1;
  localparam op_t OP_REMOVE  = 2'd2;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_EMPTY      = 2'd1;
  localparam status_t ST_FULL       = 2'd2;
  localparam status_t ST_BADHANDLE  = 2'd3;

  typedef struct packed {
    logic data_we;
    logic next_we;
    logic prev_we;
  } mem_we_t;

endpackage

// File: hw/rtl/llqm_store.sv
// Slot storage: data, next-link and prev-link memories, one registered read port.
// Depends on llqm_pkg.
module llqm_store #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [DATA_WIDTH-1:0]   rd_data,
  output logic [IDX_W-1:0]        rd_next,
  output logic [IDX_W-1:0]        rd_prev,
  input  llqm_pkg::mem_we_t       we,
  input  logic [IDX_W-1:0]        data_waddr,
  input  logic [DATA_WIDTH-1:0]   data_wdata,
  input  logic [IDX_W-1:0]        next_waddr,
  input  logic [IDX_W-1:0]        next_wdata,
  input  logic [IDX_W-1:0]        prev_waddr,
  input  logic [IDX_W-1:0]        prev_wdata
);
  import llqm_pkg::*;

  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [IDX_W-1:0]      next_mem [SLOTS];
  logic [IDX_W-1:0]      prev_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we.data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (we.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (we.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= data_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/llqm_free_enc.sv
// Priority encoder over the slot in-use map: lowest free slot.
// Depends on llqm_pkg.
module llqm_free_enc #(
  parameter int SLOTS = 16,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] in_use,
  output logic             found,
  output logic [IDX_W-1:0] idx
);
  import llqm_pkg::*;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

// File: hw/rtl/llqm_ctrl.sv
// Request sequencer: read links, unlink or append, write back, build the result.
// Depends on llqm_pkg, llqm_free_enc and the assertion macro header.
`include "linked_list_queue_manager_top_assert.svh"

module llqm_ctrl #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = $clog2(SLOTS),
  parameter int CNT_W      = $clog2(SLOTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  llqm_pkg::op_t                     in_operation,
  input  logic [llqm_pkg::ENTRY_W-1:0]      in_entry_data,
  input  logic [llqm_pkg::HANDLE_W-1:0]     in_handle,
  output logic                              out_strobe,
  output llqm_pkg::status_t                 out_status,
  output logic [llqm_pkg::ENTRY_W-1:0]      out_data,
  output logic [llqm_pkg::HANDLE_W-1:0]     out_handle,
  output logic [llqm_pkg::OCC_W-1:0]        out_occupancy,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  logic [DATA_WIDTH-1:0]             rd_data,
  input  logic [IDX_W-1:0]                  rd_next,
  input  logic [IDX_W-1:0]                  rd_prev,
  output llqm_pkg::mem_we_t                 we,
  output logic [IDX_W-1:0]                  data_waddr,
  output logic [DATA_WIDTH-1:0]             data_wdata,
  output logic [IDX_W-1:0]                  next_waddr,
  output logic [IDX_W-1:0]                  next_wdata,
  output logic [IDX_W-1:0]                  prev_waddr,
  output logic [IDX_W-1:0]                  prev_wdata
);
  import llqm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOTS-1:0]      in_use_r, in_use_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  status_t               status_r, status_nxt;
  logic [ENTRY_W-1:0]    odata_r, odata_nxt;
  logic [HANDLE_W-1:0]   ohandle_r, ohandle_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;

  op_t                   op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [IDX_W-1:0]      tgt_r;
  logic                  hnd_ok_r;

  logic                  accept;
  logic                  exec;
  logic                  unlink;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  llqm_free_enc #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_free_enc (
    .in_use (in_use_r),
    .found  (free_found),
    .idx    (free_idx)
  );

  assign busy    = (state_r == S_EXEC);
  assign accept  = start && !busy;
  assign exec    = (state_r == S_EXEC);
  assign rd_en   = accept;
  assign rd_addr = (in_operation == OP_DEQUEUE) ? head_r : IDX_W'(in_handle);

  assign out_strobe    = out_strobe_r;
  assign out_status    = status_r;
  assign out_data      = odata_r;
  assign out_handle    = ohandle_r;
  assign out_occupancy = occ_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      data_r   <= DATA_WIDTH'(in_entry_data);
      tgt_r    <= rd_addr;
      hnd_ok_r <= (32'(in_handle) < SLOTS);
    end
  end

  always_comb begin
    state_nxt      = accept ? S_EXEC : S_IDLE;
    in_use_nxt     = in_use_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_strobe_nxt = exec;
    status_nxt     = ST_OK;
    odata_nxt      = '0;
    ohandle_nxt    = '0;
    unlink         = 1'b0;
    we             = '0;
    data_waddr     = free_idx;
    data_wdata     = data_r;
    next_waddr     = tail_r;
    next_wdata     = free_idx;
    prev_waddr     = free_idx;
    prev_wdata     = tail_r;

    if (exec) begin
      case (op_r)
        OP_ENQUEUE: begin
          if (!free_found) begin
            status_nxt = ST_FULL;
          end else begin
            we.data_we = 1'b1;
            if (count_r == '0) begin
              head_nxt = free_idx;
            end else begin
              we.next_we = 1'b1;
              we.prev_we = 1'b1;
            end
            tail_nxt             = free_idx;
            in_use_nxt[free_idx] = 1'b1;
            count_nxt            = count_r + 1'b1;
            ohandle_nxt          = HANDLE_W'(free_idx);
          end
        end
        OP_DEQUEUE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            unlink = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (!hnd_ok_r || !in_use_r[tgt_r]) begin
            status_nxt = ST_BADHANDLE;
          end else begin
            unlink = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (unlink) begin
        if (tgt_r == head_r) begin
          head_nxt = rd_next;
        end else begin
          we.next_we = 1'b1;
          next_waddr = rd_prev;
          next_wdata = rd_next;
        end
        if (tgt_r == tail_r) begin
          tail_nxt = rd_prev;
        end else begin
          we.prev_we = 1'b1;
          prev_waddr = rd_next;
          prev_wdata = rd_prev;
        end
        in_use_nxt[tgt_r] = 1'b0;
        count_nxt         = count_r - 1'b1;
        odata_nxt         = ENTRY_W'(rd_data);
      end
    end

    occ_nxt = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    status_r  <= status_nxt;
    odata_r   <= odata_nxt;
    ohandle_r <= ohandle_nxt;
    occ_r     <= occ_nxt;
  end

  `LLQM_ASSERT_NOW(a_count_matches_map, 1'b1, $countones(in_use_r) == count_r,
                   "entry count differs from in-use map")
  `LLQM_ASSERT_NEXT(a_exec_gives_result, exec, out_strobe_r && !busy,
                    "request finished without a result strobe")
  `LLQM_ASSERT_NOW(a_full_only_at_capacity, exec && op_r == OP_ENQUEUE && !free_found,
                   count_r == CNT_W'(SLOTS), "pool full reported below capacity")
  `LLQM_ASSERT_NEXT(a_unlink_frees_slot, unlink, !in_use_r[$past(tgt_r)],
                    "unlinked slot still marked in use")

endmodule

// File: hw/rtl/linked_list_queue_manager_top.sv
// Queue manager top: a FIFO kept as a doubly linked list over a slot pool.
// The link read is registered as a request is accepted; the result strobe is registered from the execute state.
// No new request is taken until the previous one has finished its write-back; busy is high until then.
// Reset clears the in-use map, head, tail and count; slot memories are not cleared.
// The receiver cannot stall; each result is shown for one cycle only.
// Depends on llqm_pkg, llqm_ctrl and llqm_store.
module linked_list_queue_manager_top #(
  parameter int SLOTS      = llqm_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = llqm_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  llqm_pkg::op_t                     in_operation,
  input  logic [llqm_pkg::ENTRY_W-1:0]      in_entry_data,
  input  logic [llqm_pkg::HANDLE_W-1:0]     in_handle,
  output logic                              out_strobe,
  output llqm_pkg::status_t                 out_status,
  output logic [llqm_pkg::ENTRY_W-1:0]      out_data,
  output logic [llqm_pkg::HANDLE_W-1:0]     out_handle,
  output logic [llqm_pkg::OCC_W-1:0]        out_occupancy
);
  import llqm_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]      rd_next;
  logic [IDX_W-1:0]      rd_prev;
  mem_we_t               we;
  logic [IDX_W-1:0]      data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [IDX_W-1:0]      next_waddr;
  logic [IDX_W-1:0]      next_wdata;
  logic [IDX_W-1:0]      prev_waddr;
  logic [IDX_W-1:0]      prev_wdata;

  llqm_ctrl #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_entry_data (in_entry_data),
    .in_handle     (in_handle),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_handle    (out_handle),
    .out_occupancy (out_occupancy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .rd_next       (rd_next),
    .rd_prev       (rd_prev),
    .we            (we),
    .data_waddr    (data_waddr),
    .data_wdata    (data_wdata),
    .next_waddr    (next_waddr),
    .next_wdata    (next_wdata),
    .prev_waddr    (prev_waddr),
    .prev_wdata    (prev_wdata)
  );

  llqm_store #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .we         (we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata)
  );

endmodule

// File: verif/tb_linked_list_queue_manager_top.sv
// Self-checking testbench for linked_list_queue_manager_top: a scoreboard class tracks
// the slot pool, links and count and checks every strobed result in order.
// Depends on llqm_pkg and the linked_list_queue_manager_top RTL.
class llqm_scoreboard;
  localparam int NSLOTS = llqm_pkg::SLOTS_DEF;

  typedef logic [llqm_pkg::HANDLE_W-1:0] slot_idx_t;
  typedef logic [llqm_pkg::OCC_W-1:0]    occ_t;

  typedef struct {
    llqm_pkg::status_t                 status;
    logic [llqm_pkg::ENTRY_W-1:0]      data;
    logic [llqm_pkg::HANDLE_W-1:0]     handle;
    logic [llqm_pkg::OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic [llqm_pkg::ENTRY_W-1:0]  slot_value [NSLOTS];
  logic [llqm_pkg::HANDLE_W-1:0] next_slot [NSLOTS];
  logic [llqm_pkg::HANDLE_W-1:0] prev_slot [NSLOTS];
  bit                            occupied [NSLOTS];
  logic [llqm_pkg::HANDLE_W-1:0] head_slot;
  logic [llqm_pkg::HANDLE_W-1:0] tail_slot;
  int unsigned                   entries;
  queue_result_t                 pending_results [$];
  int unsigned                   mismatches;
  int unsigned                   requests_seen;
  int unsigned                   results_checked;
  int unsigned                   peak_entries;
  int unsigned                   status_hits [4];

  function new();
    head_slot = '0;
    tail_slot = '0;
  endfunction

  function logic [llqm_pkg::ENTRY_W-1:0] detach_slot(logic [llqm_pkg::HANDLE_W-1:0] s);
    logic [llqm_pkg::HANDLE_W-1:0] nx;
    logic [llqm_pkg::HANDLE_W-1:0] pv;
    nx = next_slot[s];
    pv = prev_slot[s];
    if (s == head_slot) head_slot = nx;
    else next_slot[pv] = nx;
    if (s == tail_slot) tail_slot = pv;
    else prev_slot[nx] = pv;
    occupied[s] = 1'b0;
    entries--;
    return slot_value[s];
  endfunction

  function void note_request(llqm_pkg::op_t op, logic [llqm_pkg::ENTRY_W-1:0] value,
                             logic [llqm_pkg::HANDLE_W-1:0] h);
    queue_result_t r;
    int            free_slot;
    slot_idx_t     slot;
    r.status = llqm_pkg::ST_OK;
    r.data   = '0;
    r.handle = '0;
    case (op)
      llqm_pkg::OP_ENQUEUE: begin
        free_slot = -1;
        for (int i = NSLOTS - 1; i >= 0; i--) if (!occupied[i]) free_slot = i;
        if (free_slot < 0) begin
          r.status = llqm_pkg::ST_FULL;
        end else begin
          slot             = slot_idx_t'(free_slot);
          slot_value[slot] = value;
          occupied[slot]   = 1'b1;
          if (entries == 0) begin
            head_slot = slot;
          end else begin
            next_slot[tail_slot] = slot;
            prev_slot[slot]      = tail_slot;
          end
          tail_slot = slot;
          entries++;
          r.handle = slot;
        end
      end
      llqm_pkg::OP_DEQUEUE: begin
        if (entries == 0) r.status = llqm_pkg::ST_EMPTY;
        else r.data = detach_slot(head_slot);
      end
      llqm_pkg::OP_REMOVE: begin
        if (entries == 0) r.status = llqm_pkg::ST_EMPTY;
        else if (!occupied[h]) r.status = llqm_pkg::ST_BADHANDLE;
        else r.data = detach_slot(h);
      end
      default: ;
    endcase
    r.occupancy = occ_t'(entries);
    if (entries > peak_entries) peak_entries = entries;
    status_hits[r.status]++;
    requests_seen++;
    pending_results.push_back(r);
  endfunction

  function void check_result(llqm_pkg::status_t status, logic [llqm_pkg::ENTRY_W-1:0] value,
                             logic [llqm_pkg::HANDLE_W-1:0] h,
                             logic [llqm_pkg::OCC_W-1:0] occupancy);
    queue_result_t e;
    if (pending_results.size() == 0) begin
      $error("result strobe with no request outstanding");
      mismatches++;
      return;
    end
    e = pending_results.pop_front();
    results_checked++;
    if (status !== e.status) begin
      $error("out_status: expected %0d, got %0d", e.status, status);
      mismatches++;
    end
    if (value !== e.data) begin
      $error("out_data: expected %h, got %h", e.data, value);
      mismatches++;
    end
    if (h !== e.handle) begin
      $error("out_handle: expected %0d, got %0d", e.handle, h);
      mismatches++;
    end
    if (occupancy !== e.occupancy) begin
      $error("out_occupancy: expected %0d, got %0d", e.occupancy, occupancy);
      mismatches++;
    end
  endfunction

  function logic [llqm_pkg::HANDLE_W-1:0] pick_queued_slot();
    logic [llqm_pkg::HANDLE_W-1:0] taken [$];
    for (int i = 0; i < NSLOTS; i++) if (occupied[i]) taken.push_back(slot_idx_t'(i));
    if (taken.size() == 0) return slot_idx_t'($urandom_range(0, NSLOTS - 1));
    return taken[$urandom_range(0, taken.size() - 1)];
  endfunction
endclass

module tb_linked_list_queue_manager_top;
  import llqm_pkg::*;

  localparam op_t         OP_UNUSED      = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PER_PHASE = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  op_t                   in_operation;
  logic [ENTRY_W-1:0]    in_entry_data;
  logic [HANDLE_W-1:0]   in_handle;
  logic                  out_strobe;
  status_t               out_status;
  logic [ENTRY_W-1:0]    out_data;
  logic [HANDLE_W-1:0]   out_handle;
  logic [OCC_W-1:0]      out_occupancy;

  llqm_scoreboard        sb;
  int unsigned           sender_idle_pct;
  int unsigned           stall_cycles;

  linked_list_queue_manager_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_entry_data (in_entry_data),
    .in_handle     (in_handle),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_handle    (out_handle),
    .out_occupancy (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_status, out_data, out_handle, out_occupancy);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", stall_cycles);
      $display("tb_linked_list_queue_manager_top: FAIL");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(op_t op, logic [ENTRY_W-1:0] value, logic [HANDLE_W-1:0] h);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_entry_data <= value;
    in_handle     <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, value, h);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic issue_random_request(int unsigned enqueue_pct);
    int unsigned         roll;
    op_t                 op;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(0, 99);
    if (roll < enqueue_pct) op = OP_ENQUEUE;
    else if (roll >= 95) op = OP_UNUSED;
    else if (roll[0]) op = OP_DEQUEUE;
    else op = OP_REMOVE;
    if ($urandom_range(0, 99) < 75) h = sb.pick_queued_slot();
    else h = HANDLE_W'($urandom_range(0, 15));
    issue_request(op, $urandom(), h);
  endtask

  task automatic run_directed();
    issue_request(OP_DEQUEUE, 32'h0, 4'd0);
    issue_request(OP_REMOVE, 32'hFFFF_FFFF, 4'd15);
    issue_request(OP_UNUSED, 32'h1234_5678, 4'd3);
    issue_request(OP_ENQUEUE, 32'h0, 4'd0);
    issue_request(OP_ENQUEUE, 32'hFFFF_FFFF, 4'd15);
    issue_request(OP_ENQUEUE, 32'h8000_0001, 4'd0);
    for (int i = 3; i < 16; i++) begin
      issue_request(OP_ENQUEUE, $urandom(), HANDLE_W'($urandom_range(0, 15)));
    end
    issue_request(OP_ENQUEUE, 32'hDEAD_BEEF, 4'd0);
    issue_request(OP_REMOVE, 32'h0, 4'd15);
    issue_request(OP_REMOVE, 32'h0, 4'd0);
    issue_request(OP_REMOVE, 32'h0, 4'd7);
    issue_request(OP_REMOVE, 32'h0, 4'd7);
    issue_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
    issue_request(OP_DEQUEUE, 32'h0, 4'd0);
    issue_request(OP_ENQUEUE, 32'h5A5A_A5A5, 4'd0);
  endtask

  initial begin
    int unsigned enqueue_pct;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_ENQUEUE;
    in_entry_data   = '0;
    in_handle       = '0;
    sender_idle_pct = 0;
    enqueue_pct     = 50;
    sb              = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 66 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // pick fill-heavy or drain-heavy stretches at random to reach full and empty
        if (n % 40 == 0) enqueue_pct = $urandom_range(0, 1) ? 70 : 30;
        issue_random_request(enqueue_pct);
      end
      wait_for_results();
    end

    repeat (8) @(negedge clk);
    $display("run covered %0d requests, %0d results checked, peak occupancy %0d",
             sb.requests_seen, sb.results_checked, sb.peak_entries);
    $display("status mix: ok %0d, empty %0d, full %0d, bad handle %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_FULL], sb.status_hits[ST_BADHANDLE]);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_linked_list_queue_manager_top: PASS");
    end else begin
      $display("tb_linked_list_queue_manager_top: FAIL");
    end
    $finish;
  end
endmodule
